// ===== src/tsbt_pkg.sv =====
// Shared types, constants and helpers of the timer sleeper blacklist table.
package tsbt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCAN_W      = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W    = 64;
  localparam int TS_W     = 64;
  localparam int CNT_W    = 32;
  localparam int GAP_W    = 32;
  localparam int PER_W    = 40;
  localparam int REM_W    = 6;
  localparam int CMD_W    = 2;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 64;

  localparam logic [TS_W-1:0] NS_PER_MS = 64'd1000000;
  localparam logic [TS_W-1:0] NS_PER_S  = 64'd1000000000;

  localparam logic [GAP_W-1:0] SHORT_GAP_RST   = NS_PER_MS[GAP_W-1:0];
  localparam logic [PER_W-1:0] RECYCLE_RST     = PER_W'(NS_PER_S << 2);
  localparam logic [PER_W-1:0] FIRE_RECENT_RST = NS_PER_S[PER_W-1:0];
  localparam logic [PER_W-1:0] IDLE_AGE_RST    = PER_W'(NS_PER_S << 1);

  localparam logic [CNT_W-1:0] CNT_MAX      = 32'h7fff_ffff;
  localparam logic [CNT_W-1:0] CNT_MIN      = 32'h8000_0000;
  localparam logic [CNT_W-1:0] CNT_POS_WRAP = 32'd100;
  localparam logic [CNT_W-1:0] CNT_NEG_WRAP = 32'hffff_ff9c;

  localparam logic [REM_W-1:0] REM_MAX = 6'd63;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRE   = 2'd0,
    CMD_EXPIRE = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SHORT_GAP   = 2'd0,
    REG_RECYCLE     = 2'd1,
    REG_FIRE_RECENT = 2'd2,
    REG_IDLE_AGE    = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXP_WB,
    ST_INS,
    ST_FIRE_RD,
    ST_FIRE_CHK,
    ST_FIRE_GAP,
    ST_FIRE_WB,
    ST_SW_D1,
    ST_SW_D2,
    ST_SW_CHK,
    ST_SW_RD,
    ST_SW_EVAL,
    ST_SW_F2,
    ST_SW_F3,
    ST_SW_E2,
    ST_SW_E3,
    ST_SW_END,
    ST_CLR_END
  } state_t;

  typedef struct packed {
    logic [GAP_W-1:0] short_gap;
    logic [PER_W-1:0] recycle;
    logic [PER_W-1:0] fire_recent;
    logic [PER_W-1:0] idle_age;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic             key_en;
    logic             fire_en;
    logic             exp_en;
    logic             cnt_en;
    logic [KEY_W-1:0] key;
    logic [TS_W-1:0]  fire;
    logic [TS_W-1:0]  exp;
    logic [CNT_W-1:0] cnt;
    logic             set_vld;
    logic             clr_vld;
    logic             clr_all;
  } mem_wr_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [TS_W-1:0]  fire;
    logic [TS_W-1:0]  exp;
    logic [CNT_W-1:0] cnt;
  } mem_rsp_t;

  typedef struct packed {
    logic            en;
    logic [TS_W-1:0] a;
    logic [TS_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic            lt;
    logic [TS_W-1:0] diff;
  } alu_rsp_t;

  typedef struct packed {
    logic             stb;
    logic             valid_sleeper;
    logic             record_found;
    logic             table_full;
    logic [REM_W-1:0] entries_removed;
  } result_t;

  function automatic logic [REM_W-1:0] sat_removed(input logic [SCAN_W-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    return (w > 32'(REM_MAX)) ? REM_MAX : w[REM_W-1:0];
  endfunction

endpackage

// ===== src/tsbt_cfg.sv =====
// Configuration register file behind the APB-style port.
module tsbt_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsbt_pkg::APB_AW-1:0] paddr,
  input  logic [tsbt_pkg::APB_DW-1:0] pwdata,
  output logic [tsbt_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output tsbt_pkg::cfg_t              cfg
);
  import tsbt_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_hit;

  assign idx    = reg_idx_t'(paddr[APB_AW-1:3]);
  assign wr_hit = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_gap   <= SHORT_GAP_RST;
      cfg_r.recycle     <= RECYCLE_RST;
      cfg_r.fire_recent <= FIRE_RECENT_RST;
      cfg_r.idle_age    <= IDLE_AGE_RST;
    end else if (wr_hit) begin
      unique case (idx)
        REG_SHORT_GAP:   cfg_r.short_gap   <= pwdata[GAP_W-1:0];
        REG_RECYCLE:     cfg_r.recycle     <= pwdata[PER_W-1:0];
        REG_FIRE_RECENT: cfg_r.fire_recent <= pwdata[PER_W-1:0];
        REG_IDLE_AGE:    cfg_r.idle_age    <= pwdata[PER_W-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SHORT_GAP:   prdata = APB_DW'(cfg_r.short_gap);
      REG_RECYCLE:     prdata = APB_DW'(cfg_r.recycle);
      REG_FIRE_RECENT: prdata = APB_DW'(cfg_r.fire_recent);
      REG_IDLE_AGE:    prdata = APB_DW'(cfg_r.idle_age);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== src/tsbt_store.sv =====
// Record storage: key, time and count memories plus per-entry valid flags.
module tsbt_store (
  input  logic               clk,
  input  logic               rst_n,
  input  tsbt_pkg::mem_rd_t  rd,
  input  tsbt_pkg::mem_wr_t  wr,
  output tsbt_pkg::mem_rsp_t rsp
);
  import tsbt_pkg::*;

  logic [KEY_W-1:0] key_mem  [TABLE_DEPTH];
  logic [TS_W-1:0]  fire_mem [TABLE_DEPTH];
  logic [TS_W-1:0]  exp_mem  [TABLE_DEPTH];
  logic [CNT_W-1:0] cnt_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  mem_rsp_t rsp_r;

  assign rsp = rsp_r;

  always_ff @(posedge clk) begin
    if (wr.en && wr.key_en)  key_mem[wr.addr]  <= wr.key;
    if (wr.en && wr.fire_en) fire_mem[wr.addr] <= wr.fire;
    if (wr.en && wr.exp_en)  exp_mem[wr.addr]  <= wr.exp;
    if (wr.en && wr.cnt_en)  cnt_mem[wr.addr]  <= wr.cnt;
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rsp_r.vld  <= vld_r[rd.addr];
      rsp_r.key  <= key_mem[rd.addr];
      rsp_r.fire <= fire_mem[rd.addr];
      rsp_r.exp  <= exp_mem[rd.addr];
      rsp_r.cnt  <= cnt_mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.clr_all) begin
      vld_r <= '0;
    end else if (wr.set_vld) begin
      vld_r[wr.addr] <= 1'b1;
    end else if (wr.clr_vld) begin
      vld_r[wr.addr] <= 1'b0;
    end
  end

endmodule

// ===== src/tsbt_alu.sv =====
// Shared 64-bit subtractor with registered difference and unsigned borrow.
module tsbt_alu (
  input  logic               clk,
  input  tsbt_pkg::alu_req_t req,
  output tsbt_pkg::alu_rsp_t rsp
);
  import tsbt_pkg::*;

  alu_rsp_t rsp_r;

  assign rsp = rsp_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      {rsp_r.lt, rsp_r.diff} <= {1'b0, req.a} - {1'b0, req.b};
    end
  end

endmodule

// ===== src/tsbt_seq.sv =====
// Command sequencer: table walks, timestamp checks and result generation.
module tsbt_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tsbt_pkg::CMD_W-1:0] in_cmd,
  input  logic [tsbt_pkg::KEY_W-1:0] in_timer_id,
  input  logic [tsbt_pkg::TS_W-1:0]  in_now_ts,
  input  tsbt_pkg::cfg_t             cfg,
  output logic                       busy,
  output tsbt_pkg::mem_rd_t          rd,
  output tsbt_pkg::mem_wr_t          wr,
  input  tsbt_pkg::mem_rsp_t         rsp,
  output tsbt_pkg::alu_req_t         alu_req,
  input  tsbt_pkg::alu_rsp_t         alu_rsp,
  output tsbt_pkg::result_t          res
);
  import tsbt_pkg::*;

  localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(TABLE_DEPTH);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(TABLE_DEPTH - 1);

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TS_W-1:0]   now_r, now_nxt;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic              chk_r, chk_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [SCAN_W-1:0] cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [TS_W-1:0]   exp_r, exp_nxt;
  logic [CNT_W-1:0]  mcnt_r, mcnt_nxt;
  logic [TS_W-1:0]   last_sweep_r, last_sweep_nxt;
  result_t           res_r, res_nxt;

  logic [IDX_W-1:0] scan_idx;
  logic [CNT_W-1:0] mcnt_new;
  logic             below;
  logic             fire_stale;
  logic             key_hit;

  assign busy       = (state_r != ST_IDLE);
  assign res        = res_r;
  assign scan_idx   = scan_r[IDX_W-1:0];
  assign below      = neg_r || alu_rsp.lt;
  assign fire_stale = (exp_r == '0) || alu_rsp.lt || (alu_rsp.diff == '0);
  assign key_hit    = rsp.vld && (rsp.key == key_r);

  always_comb begin
    if (alu_rsp.lt) begin
      mcnt_new = (mcnt_r == CNT_MAX) ? CNT_POS_WRAP : mcnt_r + 32'd1;
    end else begin
      mcnt_new = (mcnt_r == CNT_MIN) ? CNT_NEG_WRAP : mcnt_r - 32'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_t'(in_cmd))
            CMD_SWEEP: state_nxt = ST_SW_D1;
            default:   state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_r == SCAN_END) begin
          unique case (cmd_r)
            CMD_FIRE:   state_nxt = hit_nxt ? ST_FIRE_RD : (free_nxt ? ST_INS : ST_IDLE);
            CMD_EXPIRE: state_nxt = hit_nxt ? ST_EXP_WB : ST_IDLE;
            default:    state_nxt = ST_CLR_END;
          endcase
        end
      end
      ST_EXP_WB:   state_nxt = ST_IDLE;
      ST_INS:      state_nxt = ST_IDLE;
      ST_FIRE_RD:  state_nxt = ST_FIRE_CHK;
      ST_FIRE_CHK: state_nxt = (rsp.fire == '0) ? ST_IDLE : ST_FIRE_GAP;
      ST_FIRE_GAP: state_nxt = fire_stale ? ST_IDLE : ST_FIRE_WB;
      ST_FIRE_WB:  state_nxt = ST_IDLE;
      ST_SW_D1:    state_nxt = ST_SW_D2;
      ST_SW_D2:    state_nxt = ST_SW_CHK;
      ST_SW_CHK:   state_nxt = below ? ST_IDLE : ST_SW_RD;
      ST_SW_RD:    state_nxt = ST_SW_EVAL;
      ST_SW_EVAL: begin
        if (!rsp.vld) begin
          state_nxt = (scan_r == SCAN_LAST) ? ST_SW_END : ST_SW_RD;
        end else if (rsp.exp == '0) begin
          state_nxt = ST_SW_F2;
        end else begin
          state_nxt = ST_SW_E2;
        end
      end
      ST_SW_F2: state_nxt = ST_SW_F3;
      ST_SW_F3: begin
        if (below) begin
          state_nxt = (scan_r == SCAN_LAST) ? ST_SW_END : ST_SW_RD;
        end else begin
          state_nxt = ST_SW_E2;
        end
      end
      ST_SW_E2:   state_nxt = ST_SW_E3;
      ST_SW_E3:   state_nxt = (scan_r == SCAN_LAST) ? ST_SW_END : ST_SW_RD;
      ST_SW_END:  state_nxt = ST_IDLE;
      ST_CLR_END: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    now_nxt        = now_r;
    scan_nxt       = scan_r;
    chk_nxt        = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    exp_nxt        = exp_r;
    mcnt_nxt       = mcnt_r;
    last_sweep_nxt = last_sweep_r;
    res_nxt        = '0;
    rd             = '0;
    wr             = '0;
    alu_req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt  = cmd_t'(in_cmd);
          key_nxt  = in_timer_id;
          now_nxt  = in_now_ts;
          scan_nxt = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          cnt_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (scan_r != SCAN_END) begin
          rd.en       = 1'b1;
          rd.addr     = scan_idx;
          scan_nxt    = scan_r + 1'b1;
          chk_nxt     = 1'b1;
          chk_idx_nxt = scan_idx;
        end
        if (chk_r) begin
          if (key_hit && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = chk_idx_r;
          end
          if (!rsp.vld && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (rsp.vld) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (scan_r == SCAN_END) begin
          if (cmd_r == CMD_FIRE && !hit_nxt && !free_nxt) begin
            res_nxt.stb        = 1'b1;
            res_nxt.table_full = 1'b1;
          end else if (cmd_r == CMD_EXPIRE && !hit_nxt) begin
            res_nxt.stb = 1'b1;
          end
        end
      end
      ST_EXP_WB: begin
        wr.en                = 1'b1;
        wr.addr              = hit_idx_r;
        wr.exp_en            = 1'b1;
        wr.exp               = now_r;
        res_nxt.stb          = 1'b1;
        res_nxt.record_found = 1'b1;
      end
      ST_INS: begin
        wr.en                 = 1'b1;
        wr.addr               = free_idx_r;
        wr.key_en             = 1'b1;
        wr.fire_en            = 1'b1;
        wr.exp_en             = 1'b1;
        wr.cnt_en             = 1'b1;
        wr.key                = key_r;
        wr.fire               = now_r;
        wr.set_vld            = 1'b1;
        res_nxt.stb           = 1'b1;
        res_nxt.valid_sleeper = 1'b1;
      end
      ST_FIRE_RD: begin
        rd.en   = 1'b1;
        rd.addr = hit_idx_r;
      end
      ST_FIRE_CHK: begin
        mcnt_nxt = rsp.cnt;
        exp_nxt  = rsp.exp;
        if (rsp.fire == '0) begin
          wr.en                 = 1'b1;
          wr.addr               = hit_idx_r;
          wr.fire_en            = 1'b1;
          wr.fire               = now_r;
          res_nxt.stb           = 1'b1;
          res_nxt.record_found  = 1'b1;
          res_nxt.valid_sleeper = 1'b1;
        end else begin
          alu_req.en = 1'b1;
          alu_req.a  = now_r;
          alu_req.b  = rsp.exp;
        end
      end
      ST_FIRE_GAP: begin
        if (fire_stale) begin
          wr.en                = 1'b1;
          wr.addr              = hit_idx_r;
          wr.fire_en           = 1'b1;
          wr.fire              = now_r;
          res_nxt.stb          = 1'b1;
          res_nxt.record_found = 1'b1;
        end else begin
          alu_req.en = 1'b1;
          alu_req.a  = alu_rsp.diff;
          alu_req.b  = TS_W'(cfg.short_gap);
        end
      end
      ST_FIRE_WB: begin
        wr.en                 = 1'b1;
        wr.addr               = hit_idx_r;
        wr.fire_en            = 1'b1;
        wr.fire               = now_r;
        wr.cnt_en             = 1'b1;
        wr.cnt                = mcnt_new;
        res_nxt.stb           = 1'b1;
        res_nxt.record_found  = 1'b1;
        res_nxt.valid_sleeper = (mcnt_new == '0) || mcnt_new[CNT_W-1];
      end
      ST_SW_D1: begin
        alu_req.en = 1'b1;
        alu_req.a  = now_r;
        alu_req.b  = last_sweep_r;
      end
      ST_SW_D2: begin
        neg_nxt    = alu_rsp.diff[TS_W-1];
        alu_req.en = 1'b1;
        alu_req.a  = alu_rsp.diff;
        alu_req.b  = TS_W'(cfg.recycle);
      end
      ST_SW_CHK: begin
        if (below) begin
          res_nxt.stb = 1'b1;
        end else begin
          scan_nxt = '0;
          cnt_nxt  = '0;
        end
      end
      ST_SW_RD: begin
        rd.en   = 1'b1;
        rd.addr = scan_idx;
      end
      ST_SW_EVAL: begin
        exp_nxt = rsp.exp;
        if (!rsp.vld) begin
          scan_nxt = scan_r + 1'b1;
        end else begin
          alu_req.en = 1'b1;
          alu_req.a  = now_r;
          alu_req.b  = (rsp.exp == '0) ? rsp.fire : rsp.exp;
        end
      end
      ST_SW_F2: begin
        neg_nxt    = alu_rsp.diff[TS_W-1];
        alu_req.en = 1'b1;
        alu_req.a  = alu_rsp.diff;
        alu_req.b  = TS_W'(cfg.fire_recent);
      end
      ST_SW_F3: begin
        if (below) begin
          scan_nxt = scan_r + 1'b1;
        end else begin
          alu_req.en = 1'b1;
          alu_req.a  = now_r;
          alu_req.b  = exp_r;
        end
      end
      ST_SW_E2: begin
        neg_nxt    = alu_rsp.diff[TS_W-1];
        alu_req.en = 1'b1;
        alu_req.a  = alu_rsp.diff;
        alu_req.b  = TS_W'(cfg.idle_age);
      end
      ST_SW_E3: begin
        if (!below) begin
          wr.clr_vld = 1'b1;
          wr.addr    = scan_idx;
          cnt_nxt    = cnt_r + 1'b1;
        end
        scan_nxt = scan_r + 1'b1;
      end
      ST_SW_END: begin
        last_sweep_nxt          = now_r;
        res_nxt.stb             = 1'b1;
        res_nxt.entries_removed = sat_removed(cnt_r);
      end
      ST_CLR_END: begin
        wr.clr_all              = 1'b1;
        res_nxt.stb             = 1'b1;
        res_nxt.entries_removed = sat_removed(cnt_r);
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chk_r        <= 1'b0;
      res_r        <= '0;
      last_sweep_r <= '0;
    end else begin
      state_r      <= state_nxt;
      chk_r        <= chk_nxt;
      res_r        <= res_nxt;
      last_sweep_r <= last_sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    now_r      <= now_nxt;
    scan_r     <= scan_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    exp_r      <= exp_nxt;
    mcnt_r     <= mcnt_nxt;
  end

endmodule

// ===== src/timer_sleeper_blacklist_table.sv =====
// Top level of the timer sleeper blacklist table.
//
// Commands enter on start/in_cmd/in_timer_id/in_now_ts; a transfer happens
// at a clock edge with start high and busy low. Every command yields exactly
// one result, shown on the out_ ports for a single cycle with out_strobe
// high. The receiver cannot stall; the result is taken in that cycle.
// Fire, expire and clear walk all TABLE_DEPTH records through the single
// read port of the record memory, one per cycle. A sweep first checks that
// the recycle period has passed since the last sweep; if so it runs every
// valid record through the shared 64-bit subtractor.
// busy is high from the cycle after a transfer until the result cycle; a new
// command may be started in the result cycle.
// Registers (short_gap_ns, recycle_period_ns, fire_recent_ns, idle_age_ns)
// sit at byte addresses 0, 8, 16 and 24 of the APB-style port; write them
// only while the block is idle.
// Reset empties the table, zeroes the last sweep time and restores the
// register defaults; no clearing pass is needed.
module timer_sleeper_blacklist_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tsbt_pkg::CMD_W-1:0]  in_cmd,
  input  logic [tsbt_pkg::KEY_W-1:0]  in_timer_id,
  input  logic [tsbt_pkg::TS_W-1:0]   in_now_ts,
  output logic                        out_strobe,
  output logic                        out_valid_sleeper,
  output logic                        out_record_found,
  output logic                        out_table_full,
  output logic [tsbt_pkg::REM_W-1:0]  out_entries_removed,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsbt_pkg::APB_AW-1:0] paddr,
  input  logic [tsbt_pkg::APB_DW-1:0] pwdata,
  output logic [tsbt_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import tsbt_pkg::*;

  cfg_t     cfg;
  mem_rd_t  rd;
  mem_wr_t  wr;
  mem_rsp_t rsp;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  result_t  res;

  tsbt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsbt_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (rd),
    .wr    (wr),
    .rsp   (rsp)
  );

  tsbt_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  tsbt_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_cmd      (in_cmd),
    .in_timer_id (in_timer_id),
    .in_now_ts   (in_now_ts),
    .cfg         (cfg),
    .busy        (busy),
    .rd          (rd),
    .wr          (wr),
    .rsp         (rsp),
    .alu_req     (alu_req),
    .alu_rsp     (alu_rsp),
    .res         (res)
  );

  assign out_strobe          = res.stb;
  assign out_valid_sleeper   = res.valid_sleeper;
  assign out_record_found    = res.record_found;
  assign out_table_full      = res.table_full;
  assign out_entries_removed = res.entries_removed;

endmodule

// ===== src/tsbt_chk.sv =====
// Port-level checker for the timer sleeper blacklist table, with its bind.
module tsbt_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_strobe,
  input logic                       out_valid_sleeper,
  input logic                       out_record_found,
  input logic                       out_table_full,
  input logic [tsbt_pkg::REM_W-1:0] out_entries_removed
);
  import tsbt_pkg::*;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command transfer");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("command finished without a result");

  a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while a command is still running");

  a_full_excludes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_table_full) |->
      (!out_valid_sleeper && !out_record_found && out_entries_removed == '0))
    else $error("table full result carries other flags");

  a_removed_excludes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_entries_removed != '0) |->
      (!out_valid_sleeper && !out_record_found))
    else $error("removal count on a fire or expire result");

endmodule

bind timer_sleeper_blacklist_table tsbt_chk u_tsbt_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_strobe          (out_strobe),
  .out_valid_sleeper   (out_valid_sleeper),
  .out_record_found    (out_record_found),
  .out_table_full      (out_table_full),
  .out_entries_removed (out_entries_removed)
);
